### sv/box_iou_ratio_defines.svh
// Assertion helpers for the box IoU block.
`ifndef BOX_IOU_RATIO_DEFINES_SVH
`define BOX_IOU_RATIO_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BIOU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box_iou_ratio: same-cycle check failed");

// Implication after a fixed number of cycles.
`define BIOU_ASSERT_LAT(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("box_iou_ratio: latency check failed");

`endif

### sv/biou_pkg.sv
package biou_pkg;

    // Field widths
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Derived datapath widths
    localparam int EXT_W     = COORD_BITS + 1;   // signed edge difference
    localparam int AREA_W    = 2 * EXT_W;        // signed box area
    localparam int OV_W      = 2 * COORD_BITS;   // overlap area
    localparam int SUM_W     = AREA_W + 1;       // area1 + area2
    localparam int UNI_W     = SUM_W + 1;        // sum - overlap
    localparam int DEN_W     = OV_W + 1;         // divisor when dividing
    localparam int RATIO_W   = FRAC_BITS + 1;
    localparam int DIV_CELLS = FRAC_BITS;        // one quotient bit per cell

    localparam logic [RATIO_W-1:0] ONE_FIXED = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic [COORD_BITS-1:0] first_left;
        logic [COORD_BITS-1:0] first_top;
        logic [COORD_BITS-1:0] first_right;
        logic [COORD_BITS-1:0] first_bottom;
        logic [COORD_BITS-1:0] second_left;
        logic [COORD_BITS-1:0] second_top;
        logic [COORD_BITS-1:0] second_right;
        logic [COORD_BITS-1:0] second_bottom;
    } box_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               no_overlap;
        logic               zero_union;
        logic               clamped;
    } res_t;

    // Word handed from cell to cell in the divider chain
    typedef struct packed {
        res_t                 res;      // fixed result when div_en is low
        logic                 div_en;
        logic [DEN_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [FRAC_BITS-1:0] quo;
    } div_t;

endpackage

### sv/box_iou_ratio.sv
// Channel   Handshake        Payload                 Direction
// input     start / busy     boxes  (biou_pkg::box_t)  in
// result    done (strobe)    result (biou_pkg::res_t)  out
//
// One box pair per clock; busy stays low, so a transfer happens whenever start is high.
// The pipeline has four front stages (extents, products, area sum, union and
// case split), 16 divider cells that each produce one quotient bit, and the output register.
// Reset clears the valid bit of every stage; payload registers are not reset.
// done is high for one cycle per result; the receiver cannot stall, so nothing is held back.
`include "box_iou_ratio_defines.svh"

module box_iou_ratio (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  biou_pkg::box_t   boxes,
    output logic             done,
    output biou_pkg::res_t   result
);

    localparam int NC      = biou_pkg::DIV_CELLS;
    localparam int FB      = biou_pkg::FRAC_BITS;
    localparam int LATENCY = 4 + NC + 1;

    logic             accept;
    logic             chain_valid [0:NC];
    biou_pkg::div_t   chain_data  [0:NC];

    // Pipeline never backs up
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    biou_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .box       (boxes),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        biou_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Output register: pick quotient or the fixed result
    logic             done_reg;
    biou_pkg::res_t   result_reg, result_next;

    always_comb
    begin
        result_next = chain_data[NC].res;
        if (chain_data[NC].div_en)
            result_next.ratio = {1'b0, chain_data[NC].quo[FB-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain_valid[NC];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `BIOU_ASSERT_LAT(a_latency, accept, LATENCY, done)
    `BIOU_ASSERT_IMP(a_flags_excl, done, $countones({result.no_overlap, result.zero_union, result.clamped}) <= 1)
    `BIOU_ASSERT_IMP(a_flag_ratio_zero, done && (result.no_overlap || result.zero_union), result.ratio == '0)
    `BIOU_ASSERT_IMP(a_ratio_range, done, result.ratio <= biou_pkg::ONE_FIXED)

endmodule

### sv/biou_front.sv
module biou_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  biou_pkg::box_t   box,
    output logic             out_valid,
    output biou_pkg::div_t   out_data
);

    localparam int EXT_W   = biou_pkg::EXT_W;
    localparam int CB      = biou_pkg::COORD_BITS;
    localparam int AREA_W  = biou_pkg::AREA_W;
    localparam int OV_W    = biou_pkg::OV_W;
    localparam int SUM_W   = biou_pkg::SUM_W;
    localparam int UNI_W   = biou_pkg::UNI_W;
    localparam int DEN_W   = biou_pkg::DEN_W;
    localparam int RATIO_W = biou_pkg::RATIO_W;

    // Stage 1: overlap extents and box extents
    logic                    valid1_reg;
    logic signed [EXT_W-1:0] w1_reg, w1_next, h1_reg, h1_next;
    logic signed [EXT_W-1:0] dx1_reg, dx1_next, dy1_reg, dy1_next;
    logic signed [EXT_W-1:0] dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic [CB-1:0]           min_r, max_l, min_b, max_t;

    always_comb
    begin
        min_r = (box.first_right < box.second_right) ? box.first_right : box.second_right;
        max_l = (box.first_left > box.second_left) ? box.first_left : box.second_left;
        min_b = (box.first_bottom < box.second_bottom) ? box.first_bottom : box.second_bottom;
        max_t = (box.first_top > box.second_top) ? box.first_top : box.second_top;
        w1_next  = $signed({1'b0, min_r}) - $signed({1'b0, max_l});
        h1_next  = $signed({1'b0, min_b}) - $signed({1'b0, max_t});
        dx1_next = $signed({1'b0, box.first_right}) - $signed({1'b0, box.first_left});
        dy1_next = $signed({1'b0, box.first_bottom}) - $signed({1'b0, box.first_top});
        dx2_next = $signed({1'b0, box.second_right}) - $signed({1'b0, box.second_left});
        dy2_next = $signed({1'b0, box.second_bottom}) - $signed({1'b0, box.second_top});
    end

    // Stage 2: the three products
    logic                     valid2_reg;
    logic                     nov2_reg, nov2_next;
    logic [OV_W-1:0]          ov2_reg, ov2_next, ov_prod;
    logic signed [AREA_W-1:0] a1_reg, a1_next, a2_reg, a2_next;

    always_comb
    begin
        nov2_next = w1_reg[EXT_W-1] | h1_reg[EXT_W-1];
        ov_prod   = w1_reg[CB-1:0] * h1_reg[CB-1:0];
        ov2_next  = nov2_next ? '0 : ov_prod;
        a1_next   = dx1_reg * dy1_reg;
        a2_next   = dx2_reg * dy2_reg;
    end

    // Stage 3: area sum
    logic                    valid3_reg;
    logic                    nov3_reg;
    logic [OV_W-1:0]         ov3_reg;
    logic signed [SUM_W-1:0] sum3_reg, sum3_next;

    assign sum3_next = $signed({a1_reg[AREA_W-1], a1_reg})
                     + $signed({a2_reg[AREA_W-1], a2_reg});

    // Stage 4: union, case split, divider setup
    logic signed [UNI_W-1:0] uni, ov_ext;
    logic                    neg_union, uni_zero, ov_gt, ov_lt, ov_nz;
    logic                    valid4_reg;
    biou_pkg::div_t          cell4_reg, cell4_next;

    always_comb
    begin
        ov_ext    = $signed({{(UNI_W-OV_W){1'b0}}, ov3_reg});
        uni       = $signed({sum3_reg[SUM_W-1], sum3_reg}) - ov_ext;
        neg_union = uni[UNI_W-1];
        uni_zero  = (uni == '0);
        ov_gt     = ov_ext > uni;
        ov_lt     = ov_ext < uni;
        ov_nz     = (ov3_reg != '0);

        cell4_next.res.no_overlap = nov3_reg;
        cell4_next.res.zero_union = !nov3_reg && !neg_union && uni_zero;
        cell4_next.res.clamped    = !nov3_reg && ((neg_union && ov_nz) || (!neg_union && ov_gt));
        cell4_next.res.ratio      = (!nov3_reg && !neg_union && !uni_zero && !ov_lt)
                                  ? biou_pkg::ONE_FIXED : {RATIO_W{1'b0}};
        cell4_next.div_en         = !nov3_reg && !neg_union && ov_lt;
        cell4_next.rem            = {1'b0, ov3_reg};
        cell4_next.den            = uni[DEN_W-1:0];
        cell4_next.quo            = '0;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        w1_reg    <= w1_next;
        h1_reg    <= h1_next;
        dx1_reg   <= dx1_next;
        dy1_reg   <= dy1_next;
        dx2_reg   <= dx2_next;
        dy2_reg   <= dy2_next;
        nov2_reg  <= nov2_next;
        ov2_reg   <= ov2_next;
        a1_reg    <= a1_next;
        a2_reg    <= a2_next;
        nov3_reg  <= nov2_reg;
        ov3_reg   <= ov2_reg;
        sum3_reg  <= sum3_next;
        cell4_reg <= cell4_next;
    end

    assign out_valid = valid4_reg;
    assign out_data  = cell4_reg;

endmodule

### sv/biou_div_cell.sv
module biou_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  biou_pkg::div_t   in_data,
    output logic             out_valid,
    output biou_pkg::div_t   out_data
);

    localparam int DEN_W = biou_pkg::DEN_W;
    localparam int FB    = biou_pkg::FRAC_BITS;

    logic                 valid_reg;
    biou_pkg::div_t       data_reg, data_next;
    logic [DEN_W:0]       rem2, diff;
    logic                 ge;

    // One restoring step: shift remainder, try subtract, shift in quotient bit
    always_comb
    begin
        rem2      = {in_data.rem, 1'b0};
        diff      = rem2 - {1'b0, in_data.den};
        ge        = (rem2 >= {1'b0, in_data.den});
        data_next = in_data;
        data_next.rem = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        data_next.quo = {in_data.quo[FB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
